FILE: design/ppem_pkg.sv
package ppem_pkg;

    // Widths of the sample fields and the window register.
    localparam int SAMPLE_W = 10;
    localparam int WLEN_W = 16;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 16'd1000;

    // Widths of the result fields.
    localparam int VOLTS_W = 8;
    localparam int MA_W = 15;
    localparam int WATTS_W = 12;
    localparam int RADIO_W = 10;
    localparam int WH_W = 35;

    // Stream data widths (fields packed from bit 0, padded to whole bytes).
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 80;

    // Arithmetic constants of the conversions.
    localparam int VOLT_MUL = 300;
    localparam int VOLT_OFS = 14000;
    localparam int VOLT_N_W = 19;
    localparam int AMP_MUL = 17675;
    localparam int AMP_SHIFT = 10;
    localparam int AMP_P_W = 25;
    localparam int PIV_W = 18;
    localparam int PWR_P_W = 32;
    // Division by 1024000 is a shift by 13 followed by a division by 125.
    localparam int WATT_SHIFT = 13;
    localparam int ENERGY_MUL = 7;
    localparam int ENERGY_ADD_W = 15;

    // Division by a constant: q = (n * RECIP) >> RECIP_SHIFT, exact for every
    // n below 2^DIV_N_W with the reciprocals rounded up.
    localparam int DIV_N_W = 19;
    localparam int RECIP_W = 24;
    localparam int RECIP_SHIFT = 30;
    localparam int DIV_P_W = DIV_N_W + RECIP_W;
    localparam int DIV_Q_W = DIV_P_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] VOLT_RECIP = 24'd759365;
    localparam logic [RECIP_W-1:0] WATT_RECIP = 24'd8589935;

    // Energy accumulator and its running watt-hour quotient and remainder.
    localparam int ACC_W = 48;
    localparam int WH_DIV = 9600;
    localparam int WH_REM_W = 14;
    localparam int WH_SUM_W = 16;
    localparam logic [ACC_W-1:0] ACC_MAX = '1;
    localparam logic [ACC_W-1:0] WH_SAT = ACC_MAX / ACC_W'(WH_DIV);
    localparam logic [WH_REM_W-1:0] WH_SAT_REM = WH_REM_W'(ACC_MAX % ACC_W'(WH_DIV));

    // Queue between front and back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

    // Peaks of one closed window.
    typedef struct packed {
        logic [SAMPLE_W-1:0] peak_volt;
        logic [SAMPLE_W-1:0] peak_current;
    } t_peak;

    // Which constant the divider divides by.
    typedef enum logic {
        DIV_VOLTS,
        DIV_WATTS
    } t_div_kind;

    // Divider request and response.
    typedef struct packed {
        logic               start;
        t_div_kind          kind;
        logic [DIV_N_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quotient;
    } t_div_rsp;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        B_IDLE,
        B_WAIT_V,
        B_MUL_A,
        B_MUL_B,
        B_WAIT_W,
        B_ACC,
        B_OUT
    } t_back_state;

endpackage

FILE: design/ppem_front.sv
module ppem_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_full,
    input  logic [ppem_pkg::SAMPLE_W-1:0] i_volt_sample,
    input  logic [ppem_pkg::SAMPLE_W-1:0] i_current_sample,
    input  logic                          i_cfg_valid,
    input  logic [ppem_pkg::WLEN_W-1:0]   i_cfg_data,
    output logic                          o_ready,
    output logic                          o_push,
    output ppem_pkg::t_peak               o_peak
);

    logic [ppem_pkg::WLEN_W-1:0]   r_wlen;
    logic [ppem_pkg::WLEN_W-1:0]   r_count;
    logic [ppem_pkg::SAMPLE_W-1:0] r_pv;
    logic [ppem_pkg::SAMPLE_W-1:0] r_pi;
    logic [ppem_pkg::SAMPLE_W-1:0] n_pv;
    logic [ppem_pkg::SAMPLE_W-1:0] n_pi;
    logic [ppem_pkg::WLEN_W:0]     n_count;
    logic                          accept;
    logic                          close;

    // A request is taken whenever the queue has room for a closed window.
    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // Fold the pair into the peaks and count it.
    assign n_pv    = (i_volt_sample > r_pv) ? i_volt_sample : r_pv;
    assign n_pi    = (i_current_sample > r_pi) ? i_current_sample : r_pi;
    assign n_count = {1'b0, r_count} + 1'b1;
    assign close   = n_count >= {1'b0, r_wlen};

    assign o_push = accept && close;
    assign o_peak = '{peak_volt: n_pv, peak_current: n_pi};

    // Window length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= ppem_pkg::WLEN_RESET;
        end else if (i_cfg_valid) begin
            r_wlen <= i_cfg_data;
        end
    end

    // Window count and running peaks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pv    <= '0;
            r_pi    <= '0;
        end else if (accept) begin
            if (close) begin
                r_count <= '0;
                r_pv    <= '0;
                r_pi    <= '0;
            end else begin
                r_count <= n_count[ppem_pkg::WLEN_W-1:0];
                r_pv    <= n_pv;
                r_pi    <= n_pi;
            end
        end
    end

endmodule

FILE: design/ppem_fifo.sv
module ppem_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ppem_pkg::t_peak i_wdata,
    input  logic            i_pop,
    output ppem_pkg::t_peak o_rdata,
    output logic            o_full,
    output logic            o_empty
);

    ppem_pkg::t_peak                r_mem [ppem_pkg::FIFO_DEPTH];
    logic [ppem_pkg::FIFO_AW-1:0]   r_wptr;
    logic [ppem_pkg::FIFO_AW-1:0]   r_rptr;
    logic [ppem_pkg::FIFO_CW-1:0]   r_cnt;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = r_cnt == ppem_pkg::FIFO_CW'(ppem_pkg::FIFO_DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == ppem_pkg::FIFO_AW'(ppem_pkg::FIFO_DEPTH - 1))
                          ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == ppem_pkg::FIFO_AW'(ppem_pkg::FIFO_DEPTH - 1))
                          ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: design/ppem_div.sv
module ppem_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppem_pkg::t_div_req i_req,
    output ppem_pkg::t_div_rsp o_rsp
);

    logic [ppem_pkg::RECIP_W-1:0] recip;
    logic [ppem_pkg::DIV_P_W-1:0] prod;
    logic [ppem_pkg::DIV_Q_W-1:0] r_quo;
    logic                         r_done;

    // Pick the reciprocal of the requested divisor.
    always_comb begin
        case (i_req.kind)
            ppem_pkg::DIV_VOLTS: begin
                recip = ppem_pkg::VOLT_RECIP;
            end
            ppem_pkg::DIV_WATTS: begin
                recip = ppem_pkg::WATT_RECIP;
            end
            default: begin
                recip = ppem_pkg::VOLT_RECIP;
            end
        endcase
    end

    // Multiply by the reciprocal; the quotient is the top of the product.
    assign prod = ppem_pkg::DIV_P_W'(i_req.dividend) * ppem_pkg::DIV_P_W'(recip);

    assign o_rsp = '{done: r_done, quotient: r_quo};

    // Quotient register.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= prod[ppem_pkg::DIV_P_W-1:ppem_pkg::RECIP_SHIFT];
        end
    end

    // Done is a registered copy of start, high in the cycle after each start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_req.start;
        end
    end

endmodule

FILE: design/ppem_back.sv
module ppem_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  ppem_pkg::t_peak                   i_peak,
    output logic                              o_pop,
    output ppem_pkg::t_div_req                o_div_req,
    input  ppem_pkg::t_div_rsp                i_div_rsp,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ppem_pkg::OUT_DATA_W-1:0]   o_data
);

    ppem_pkg::t_back_state           r_state, n_state;
    logic [ppem_pkg::SAMPLE_W-1:0]   r_pi, n_pi;
    logic [ppem_pkg::MA_W-1:0]       r_ma, n_ma;
    logic [ppem_pkg::VOLTS_W-1:0]    r_volts, n_volts;
    logic [ppem_pkg::PIV_W-1:0]      r_piv, n_piv;
    logic [ppem_pkg::WATTS_W-1:0]    r_watts, n_watts;
    logic [ppem_pkg::ACC_W-1:0]      r_wh, n_wh;
    logic [ppem_pkg::WH_REM_W-1:0]   r_rem, n_rem;
    logic [ppem_pkg::ACC_W-1:0]      r_acc, n_acc;
    logic [ppem_pkg::DIV_N_W-1:0]    r_dvd, n_dvd;
    ppem_pkg::t_div_kind             r_kind, n_kind;
    logic                            r_start, n_start;
    logic                            r_out_valid, n_out_valid;
    logic [ppem_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic [ppem_pkg::VOLT_N_W-1:0]   volt_num;
    logic [ppem_pkg::AMP_P_W-1:0]    amp_prod;
    logic [ppem_pkg::PWR_P_W-1:0]    pwr_prod;
    logic [ppem_pkg::ENERGY_ADD_W-1:0] energy_add;
    logic [ppem_pkg::ACC_W:0]        acc_sum;
    logic [ppem_pkg::WH_SUM_W-1:0]   rem_sum;
    logic [ppem_pkg::WH_SUM_W-1:0]   rem_left;
    logic [1:0]                      wh_step;

    // Datapath terms used by the sequencer.
    assign volt_num = ppem_pkg::VOLT_N_W'(i_peak.peak_volt)
                    * ppem_pkg::VOLT_N_W'(ppem_pkg::VOLT_MUL)
                    + ppem_pkg::VOLT_N_W'(ppem_pkg::VOLT_OFS);
    assign amp_prod = ppem_pkg::AMP_P_W'(i_peak.peak_current)
                    * ppem_pkg::AMP_P_W'(ppem_pkg::AMP_MUL);
    assign pwr_prod = ppem_pkg::PWR_P_W'(r_piv) * ppem_pkg::PWR_P_W'(ppem_pkg::AMP_MUL);
    assign energy_add = ppem_pkg::ENERGY_ADD_W'(r_watts)
                      * ppem_pkg::ENERGY_ADD_W'(ppem_pkg::ENERGY_MUL);
    assign acc_sum = {1'b0, r_acc} + (ppem_pkg::ACC_W + 1)'(energy_add);
    assign rem_sum = ppem_pkg::WH_SUM_W'(r_rem) + ppem_pkg::WH_SUM_W'(energy_add);

    // The watt-hour remainder plus this window's energy holds at most three more
    // whole watt hours; take them out by comparing against the multiples.
    always_comb begin
        if (rem_sum >= ppem_pkg::WH_SUM_W'(3 * ppem_pkg::WH_DIV)) begin
            wh_step  = 2'd3;
            rem_left = rem_sum - ppem_pkg::WH_SUM_W'(3 * ppem_pkg::WH_DIV);
        end else if (rem_sum >= ppem_pkg::WH_SUM_W'(2 * ppem_pkg::WH_DIV)) begin
            wh_step  = 2'd2;
            rem_left = rem_sum - ppem_pkg::WH_SUM_W'(2 * ppem_pkg::WH_DIV);
        end else if (rem_sum >= ppem_pkg::WH_SUM_W'(ppem_pkg::WH_DIV)) begin
            wh_step  = 2'd1;
            rem_left = rem_sum - ppem_pkg::WH_SUM_W'(ppem_pkg::WH_DIV);
        end else begin
            wh_step  = 2'd0;
            rem_left = rem_sum;
        end
    end

    assign o_div_req = '{start: r_start, kind: r_kind, dividend: r_dvd};
    assign o_valid   = r_out_valid;
    assign o_data    = r_out_data;

    // Next state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_pi        = r_pi;
        n_ma        = r_ma;
        n_volts     = r_volts;
        n_piv       = r_piv;
        n_watts     = r_watts;
        n_wh        = r_wh;
        n_rem       = r_rem;
        n_acc       = r_acc;
        n_dvd       = r_dvd;
        n_kind      = r_kind;
        n_start     = 1'b0;
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;
        case (r_state)
            ppem_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_pi    = i_peak.peak_current;
                    n_ma    = amp_prod[ppem_pkg::AMP_P_W-1:ppem_pkg::AMP_SHIFT];
                    n_dvd   = volt_num;
                    n_kind  = ppem_pkg::DIV_VOLTS;
                    n_start = 1'b1;
                    n_state = ppem_pkg::B_WAIT_V;
                end
            end
            ppem_pkg::B_WAIT_V: begin
                if (i_div_rsp.done) begin
                    n_volts = i_div_rsp.quotient[ppem_pkg::VOLTS_W-1:0];
                    n_state = ppem_pkg::B_MUL_A;
                end
            end
            ppem_pkg::B_MUL_A: begin
                n_piv   = ppem_pkg::PIV_W'(r_pi) * ppem_pkg::PIV_W'(r_volts);
                n_state = ppem_pkg::B_MUL_B;
            end
            ppem_pkg::B_MUL_B: begin
                n_dvd   = pwr_prod[ppem_pkg::PWR_P_W-1:ppem_pkg::WATT_SHIFT];
                n_kind  = ppem_pkg::DIV_WATTS;
                n_start = 1'b1;
                n_state = ppem_pkg::B_WAIT_W;
            end
            ppem_pkg::B_WAIT_W: begin
                if (i_div_rsp.done) begin
                    n_watts = i_div_rsp.quotient[ppem_pkg::WATTS_W-1:0];
                    n_state = ppem_pkg::B_ACC;
                end
            end
            ppem_pkg::B_ACC: begin
                // Saturating add of this window's energy; the watt-hour total
                // follows the accumulator as quotient and remainder.
                if (acc_sum[ppem_pkg::ACC_W]) begin
                    n_acc = '1;
                    n_wh  = ppem_pkg::WH_SAT;
                    n_rem = ppem_pkg::WH_SAT_REM;
                end else begin
                    n_acc = acc_sum[ppem_pkg::ACC_W-1:0];
                    n_wh  = r_wh + ppem_pkg::ACC_W'(wh_step);
                    n_rem = rem_left[ppem_pkg::WH_REM_W-1:0];
                end
                n_state = ppem_pkg::B_OUT;
            end
            ppem_pkg::B_OUT: begin
                // Load the output register once it is free or being drained.
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_wh[ppem_pkg::WH_W-1:0],
                                   r_watts[ppem_pkg::WATTS_W-1:2],
                                   r_watts,
                                   r_ma,
                                   r_volts};
                    n_state     = ppem_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = ppem_pkg::B_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppem_pkg::B_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_wh        <= '0;
            r_rem       <= '0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
            r_acc       <= n_acc;
            r_wh        <= n_wh;
            r_rem       <= n_rem;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pi       <= n_pi;
        r_ma       <= n_ma;
        r_volts    <= n_volts;
        r_piv      <= n_piv;
        r_watts    <= n_watts;
        r_dvd      <= n_dvd;
        r_kind     <= n_kind;
        r_out_data <= n_out_data;
    end

endmodule

FILE: design/peak_power_energy_meter.sv
// A pair that does not close a window only updates the count and peaks. A closing pair
// is queued; the back end pops one at a time, waits on the volts division, multiplies,
// waits on the watts division, adds the energy and loads the output register when free.
// Throughput: one pair per cycle while the two-entry queue has room.
// Reset: synchronous, active low; clears counts, peaks, the energy total and the
// queue, and sets the window length to 1000.
module peak_power_energy_meter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [9:0] volt_sample, [19:10] current_sample, [23:20] zero.
    input  logic [ppem_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] volts, [22:8] wire_milliamps, [34:23] power_watts,
    // [44:35] radio_power, [79:45] total_watt_hours.
    output logic [ppem_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ppem_pkg::WLEN_W-1:0]         i_cfg_data
);

    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
    ppem_pkg::t_peak    peak_in;
    ppem_pkg::t_peak    peak_out;
    ppem_pkg::t_div_req div_req;
    ppem_pkg::t_div_rsp div_rsp;

    assign o_cfg_ready = 1'b1;

    // Front: window counting and peak tracking.
    ppem_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .i_full           (full),
        .i_volt_sample    (s_axis_tdata[ppem_pkg::SAMPLE_W-1:0]),
        .i_current_sample (s_axis_tdata[2*ppem_pkg::SAMPLE_W-1:ppem_pkg::SAMPLE_W]),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .o_ready          (s_axis_tready),
        .o_push           (push),
        .o_peak           (peak_in)
    );

    // Queue of closed windows.
    ppem_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (peak_in),
        .i_pop   (pop),
        .o_rdata (peak_out),
        .o_full  (full),
        .o_empty (empty)
    );

    // Shared divider by constants, one multiply by a reciprocal.
    ppem_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Back: conversions, energy total and output register.
    ppem_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_peak    (peak_out),
        .o_pop     (pop),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata)
    );

    // A closed window is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("window pushed into full queue");

    // The back end only pops an entry that exists.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    // A new division never starts while one finishes.
    a_div_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.done)
        else $error("divider restarted while completing");

    // Each division start is answered on the next cycle, with no start right behind it.
    a_div_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> div_rsp.done && !div_req.start)
        else $error("divider request sequencing broken");

endmodule

FILE: verif/tb_peak_power_energy_meter.sv
`timescale 1ns / 1ps

module tb_peak_power_energy_meter;
    import ppem_pkg::*;

    // Part of the settling wait in wait_drained.
    localparam int LATENCY = 9;
    localparam int RANDOM_ITEMS = 1935;
    localparam int LONG_HOLD = 600;
    localparam int PRESSURE_ITEMS = 24;
    localparam logic [ACC_W-1:0] ENERGY_MAX = '1;

    // One reading, laid out as on m_axis_tdata (volts in the lowest bits).
    typedef struct packed {
        logic [WH_W-1:0]    watt_hours;
        logic [RADIO_W-1:0] radio;
        logic [WATTS_W-1:0] watts;
        logic [MA_W-1:0]    milliamps;
        logic [VOLTS_W-1:0] volts;
    } meter_reading_t;

    typedef enum logic {
        ROW_WINDOW,
        ROW_PAIR
    } row_kind_t;

    // One row of the directed sequence.
    typedef struct packed {
        row_kind_t           kind;
        logic [WLEN_W-1:0]   wlen;
        logic [SAMPLE_W-1:0] volt;
        logic [SAMPLE_W-1:0] amp;
        logic                typed;
        meter_reading_t      want;
    } stim_row_t;

    // Travels with each offered pair so that a typed reading replaces the predicted one.
    typedef struct packed {
        logic           typed;
        meter_reading_t want;
    } pair_note_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [9:0] volt_sample, [19:10] current_sample, [23:20] zero.
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] volts, [22:8] wire_milliamps, [34:23] power_watts,
    // [44:35] radio_power, [79:45] total_watt_hours.
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [WLEN_W-1:0]     i_cfg_data = '0;

    // Predicted state of the meter.
    logic [WLEN_W-1:0]   window_len;
    logic [WLEN_W-1:0]   pairs_in_window;
    logic [SAMPLE_W-1:0] peak_v;
    logic [SAMPLE_W-1:0] peak_i;
    logic [ACC_W-1:0]    energy_total;

    meter_reading_t expected_readings[$];
    pair_note_t     pair_notes[$];

    int errors = 0;
    int readings_checked = 0;
    int pairs_sent = 0;
    int windows_written = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;

    peak_power_energy_meter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Fold one pair into the peaks and, when the window closes, compute its reading.
    task automatic fold_pair(input logic [SAMPLE_W-1:0] v, input logic [SAMPLE_W-1:0] c,
                             output logic closed, output meter_reading_t r);
        logic [16:0] count;
        logic [63:0] volts_q;
        logic [63:0] ma_q;
        logic [63:0] watts_q;
        logic [63:0] add_q;
        if (v > peak_v) begin
            peak_v = v;
        end
        if (c > peak_i) begin
            peak_i = c;
        end
        count = pairs_in_window + 17'd1;
        closed = (count >= window_len);
        r = '0;
        if (!closed) begin
            pairs_in_window = count[WLEN_W-1:0];
        end else begin
            // Conversions of the peaks, truncated at every division.
            volts_q = (64'(peak_v) * 300 + 14000) / 1414;
            ma_q = (64'(peak_i) * 17675) / 1024;
            watts_q = (64'(peak_i) * volts_q * 17675) / 1024000;
            // Seven units of energy per watt; the total sticks at its maximum.
            add_q = 7 * watts_q;
            if (add_q > 64'(ENERGY_MAX) - 64'(energy_total)) begin
                energy_total = ENERGY_MAX;
            end else begin
                energy_total = energy_total + add_q[ACC_W-1:0];
            end
            r.volts = volts_q[VOLTS_W-1:0];
            r.milliamps = ma_q[MA_W-1:0];
            r.watts = watts_q[WATTS_W-1:0];
            r.radio = watts_q[WATTS_W-1:2];
            r.watt_hours = WH_W'(64'(energy_total) / 9600);
            pairs_in_window = '0;
            peak_v = '0;
            peak_i = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Follow accepted writes and pairs and queue the readings they lead to.
    always @(posedge i_clk) begin
        pair_note_t     note;
        logic           closed;
        meter_reading_t predicted;
        if (!i_rst_n) begin
            window_len = 16'd1000;
            pairs_in_window = '0;
            peak_v = '0;
            peak_i = '0;
            energy_total = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                window_len = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                note = '0;
                if (pair_notes.size() != 0) begin
                    note = pair_notes.pop_front();
                end
                fold_pair(s_axis_tdata[SAMPLE_W-1:0], s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W],
                          closed, predicted);
                if (note.typed) begin
                    expected_readings.push_back(note.want);
                end else if (closed) begin
                    expected_readings.push_back(predicted);
                end
            end
        end
    end

    // Compare each delivered reading with the oldest one expected.
    always @(posedge i_clk) begin
        meter_reading_t got;
        meter_reading_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_readings.size() == 0) begin
                $display("%0t: no reading expected, got %h", $time, got);
                errors++;
            end else begin
                want = expected_readings.pop_front();
                readings_checked++;
                check_field("volts", want.volts, got.volts);
                check_field("wire_milliamps", want.milliamps, got.milliamps);
                check_field("power_watts", want.watts, got.watts);
                check_field("radio_power", want.radio, got.radio);
                check_field("total_watt_hours", want.watt_hours, got.watt_hours);
            end
        end
    end

    // Output side: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            m_axis_tready <= 1'b0;
            holds_served <= holds_served + 1;
            hold_left <= LONG_HOLD;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one pair after a random gap and wait for its request to be taken.
    task automatic send_pair(input logic [SAMPLE_W-1:0] v, input logic [SAMPLE_W-1:0] c,
                             input logic typed, input meter_reading_t want);
        pair_note_t note;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        note.typed = typed;
        note.want = want;
        pair_notes.push_back(note);
        s_axis_tdata <= {{(IN_DATA_W - 2 * SAMPLE_W){1'b0}}, c, v};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        pairs_sent++;
    endtask

    // Stop offering, let every expected reading arrive, then let the block settle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WLEN_W-1:0] len);
        i_cfg_data <= len;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        windows_written++;
    endtask

    function automatic stim_row_t window_row(input logic [WLEN_W-1:0] len);
        stim_row_t row;
        row = '0;
        row.kind = ROW_WINDOW;
        row.wlen = len;
        return row;
    endfunction

    function automatic stim_row_t pair_row(input logic [SAMPLE_W-1:0] v,
                                           input logic [SAMPLE_W-1:0] c);
        stim_row_t row;
        row = '0;
        row.kind = ROW_PAIR;
        row.volt = v;
        row.amp = c;
        return row;
    endfunction

    function automatic stim_row_t reading_row(input logic [SAMPLE_W-1:0] v,
                                              input logic [SAMPLE_W-1:0] c,
                                              input int volts, input int ma, input int watts,
                                              input int radio, input int wh);
        stim_row_t row;
        row = pair_row(v, c);
        row.typed = 1'b1;
        row.want.volts = VOLTS_W'(volts);
        row.want.milliamps = MA_W'(ma);
        row.want.watts = WATTS_W'(watts);
        row.want.radio = RADIO_W'(radio);
        row.want.watt_hours = WH_W'(wh);
        return row;
    endfunction

    // Mostly random readings, with a fair share of both rails.
    function automatic logic [SAMPLE_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end
        return SAMPLE_W'($urandom_range(1023));
    endfunction

    initial begin
        stim_row_t      directed[$];
        int             random_sent;
        int             pick;
        int             burst;
        logic [WLEN_W-1:0] len;

        // The first pair runs under the reset window of 1000 and closes nothing;
        // lowering the window to one then closes it on the next pair.
        directed.push_back(pair_row(10'd0, 10'd0));
        directed.push_back(window_row(16'd1));
        directed.push_back(reading_row(10'd0, 10'd0, 9, 0, 0, 0, 0));
        directed.push_back(reading_row(10'h3FF, 10'h3FF, 226, 17657, 3990, 997, 2));
        directed.push_back(reading_row(10'h3FF, 10'd0, 226, 0, 0, 0, 2));
        // Peaks taken from different pairs of one window.
        directed.push_back(window_row(16'd3));
        directed.push_back(pair_row(10'd5, 10'd900));
        directed.push_back(pair_row(10'd1000, 10'd3));
        directed.push_back(pair_row(10'd7, 10'd7));
        // Longest window, then lowered below the count already reached.
        directed.push_back(window_row(16'hFFFF));
        directed.push_back(pair_row(10'h155, 10'h2AA));
        directed.push_back(pair_row(10'h2AA, 10'h155));
        directed.push_back(pair_row(10'd1, 10'd1));
        directed.push_back(pair_row(10'h200, 10'h200));
        directed.push_back(window_row(16'd2));
        directed.push_back(pair_row(10'd3, 10'd3));
        // A zero window acts as a window of one.
        directed.push_back(window_row(16'd0));
        directed.push_back(pair_row(10'h200, 10'h200));
        directed.push_back(pair_row(10'd0, 10'h3FF));
        directed.push_back(pair_row(10'h3FF, 10'h3FF));

        tx_idle_pct = 27;
        rx_idle_pct = 45;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_WINDOW) begin
                wait_drained();
                write_window(directed[i].wlen);
            end else begin
                send_pair(directed[i].volt, directed[i].amp, directed[i].typed,
                          directed[i].want);
            end
        end

        // Hold the output off for a long stretch while pairs keep coming,
        // so that the queue fills and the input stalls.
        wait_drained();
        write_window(16'd1);
        holds_asked++;
        random_sent = 0;
        repeat (PRESSURE_ITEMS) begin
            send_pair(random_sample(), random_sample(), 1'b0, '0);
            random_sent++;
        end

        // Random windows, each burst under a freshly written length.
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (random_sent >= RANDOM_ITEMS / 3) begin
                tx_idle_pct = 45;
                rx_idle_pct = 27;
            end
            pick = $urandom_range(99);
            if (pick < 6) begin
                len = '0;
            end else if (pick < 12) begin
                len = '1;
            end else if (pick < 16) begin
                len = WLEN_W'($urandom_range(65535, 7));
            end else begin
                len = WLEN_W'($urandom_range(6, 1));
            end
            burst = (len > 64) ? $urandom_range(8, 1) : $urandom_range(24, 4);
            wait_drained();
            write_window(len);
            repeat (burst) begin
                send_pair(random_sample(), random_sample(), 1'b0, '0);
                random_sent++;
            end
        end

        wait_drained();
        $display("Run covered %0d sample pairs under %0d window-length writes,",
                 pairs_sent, windows_written);
        $display("with %0d closed-window readings checked and one long output stall.",
                 readings_checked);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Safety net against a hung handshake.
    initial begin
        #(25_000_000);
        $display("Timeout at %0t with %0d readings outstanding", $time,
                 expected_readings.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
design/ppem_pkg.sv
design/ppem_front.sv
design/ppem_fifo.sv
design/ppem_div.sv
design/ppem_back.sv
design/peak_power_energy_meter.sv
verif/tb_peak_power_energy_meter.sv
